[sv/rsas_pkg.sv]
// Shared constants and control types for the rotated sorted array search block.
`default_nettype none

package rsas_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned OP_W         = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic table_clear;
    logic elem_append;
    logic srch_start;
    logic probe_issue;
    logic probe_eval;
    logic res_load;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic range_empty;
    logic probe_hit;
  } sts_t;

endpackage

`default_nettype wire

[sv/rsas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rsas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/rsas_ctrl.sv]
// Controller state machine: input handshake, probe sequencing and output register valid.
`default_nettype none

module rsas_ctrl
  import rsas_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [OP_W-1:0] op_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire sts_t            sts_i,
  output cmd_t                 cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (op_i)
            OP_CLEAR:  cmd_o.table_clear = 1'b1;
            OP_APPEND: cmd_o.elem_append = 1'b1;
            OP_SEARCH: begin
              cmd_o.srch_start = 1'b1;
              state_d          = S_ADDR;
            end
            default: ;
          endcase
        end
      end
      S_ADDR: begin
        if (sts_i.range_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.probe_issue = 1'b1;
          state_d           = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.probe_eval = 1'b1;
        state_d          = sts_i.probe_hit ? S_DONE : S_ADDR;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/rsas_dp.sv]
// Datapath: element store, minimum tracking, search bounds and result registers.
`default_nettype none

module rsas_dp
  import rsas_pkg::*;
#(
  parameter int unsigned Capacity = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [DATA_W-1:0] value_i,
  input  wire cmd_t                     cmd_i,
  output sts_t                          sts_o,
  output logic                          found_o,
  output logic             [POS_W-1:0]  position_o
);

  localparam int unsigned IW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned LW = CW + 1;

  logic        [CW-1:0]     count_q;
  logic signed [DATA_W-1:0] min_q;
  logic        [IW-1:0]     offset_q;
  logic signed [DATA_W-1:0] key_q;
  logic signed [LW-1:0]     lo_q, hi_q;
  logic        [IW-1:0]     mid_q;
  logic                     srch_found_q;
  logic        [IW-1:0]     srch_pos_q;

  logic signed [LW:0]       sum;
  logic        [IW-1:0]     mid;
  logic        [LW-1:0]     phys;
  logic        [IW-1:0]     rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  logic                     not_full;
  logic        [IW+POS_W-1:0] pos_ext;

  assign not_full = count_q != CW'(Capacity);

  // bounds are non-negative whenever the range is open, so the halving is a shift
  assign sum  = {lo_q[LW-1], lo_q} + {hi_q[LW-1], hi_q};
  assign mid  = sum[IW:1];
  assign phys = (LW'(offset_q) + LW'(mid) >= LW'(count_q))
              ? LW'(offset_q) + LW'(mid) - LW'(count_q)
              : LW'(offset_q) + LW'(mid);
  assign rd_addr = phys[IW-1:0];

  rsas_ram #(
    .Width (DATA_W),
    .Depth (Capacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.elem_append && not_full),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (value_i),
    .re_i    (cmd_i.probe_issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign sts_o.range_empty = lo_q > hi_q;
  assign sts_o.probe_hit   = rd_data == key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      min_q    <= '0;
      offset_q <= '0;
    end else if (cmd_i.table_clear) begin
      count_q  <= '0;
      min_q    <= '0;
      offset_q <= '0;
    end else if (cmd_i.elem_append && not_full) begin
      // keep the first position of the minimum
      if (count_q == '0 || value_i < min_q) begin
        min_q    <= value_i;
        offset_q <= count_q[IW-1:0];
      end
      count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.srch_start) begin
      key_q        <= value_i;
      lo_q         <= '0;
      hi_q         <= LW'(count_q) - LW'(1);
      srch_found_q <= 1'b0;
      srch_pos_q   <= '0;
    end
    if (cmd_i.probe_issue) begin
      mid_q <= mid;
    end
    if (cmd_i.probe_eval) begin
      if (rd_data == key_q) begin
        srch_found_q <= 1'b1;
        srch_pos_q   <= mid_q;
      end else if (rd_data > key_q) begin
        hi_q <= LW'(mid_q) - LW'(1);
      end else begin
        lo_q <= LW'(mid_q) + LW'(1);
      end
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, srch_pos_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      found_o    <= srch_found_q;
      position_o <= pos_ext[POS_W-1:0];
    end
  end

endmodule

`default_nettype wire

[sv/rotated_sorted_array_search_core.sv]
// Rotated sorted array search: a table of signed words searched by rotated binary search.
//
// Input channel (in_valid_i/in_ready_o) carries operation_i and value_i. Operation
// CLEAR empties the table, APPEND writes value_i at the next free slot (dropped when
// full) and SEARCH looks for value_i. Only a search produces an output beat on
// out_valid_o/out_ready_i with found_o and position_o (logical, unrotated index,
// zero when not found). CLEAR and APPEND leave the controller idle, so they can stream
// back to back. A search makes each probe as a memory read, then a compare, for up to
// floor(log2(n))+1 probes over n entries, ends on a hit or an empty range and then loads
// the output register. The registered store read splits each probe into read and compare.
// A finished result waits in the output register; while the receiver stalls the block still
// takes CLEAR and APPEND beats, and a further search stops at its end until the register
// is free. Reset empties the table and clears the output valid; store contents are not
// cleared and no clearing pass is needed.
`default_nettype none

module rotated_sorted_array_search_core
  import rsas_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic        [OP_W-1:0]   operation_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          found_o,
  output logic             [POS_W-1:0]  position_o
);

  cmd_t cmd;
  sts_t sts;

  rsas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rsas_dp #(
    .Capacity (CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .found_o    (found_o),
    .position_o (position_o)
  );

endmodule

`default_nettype wire

[sv/rsas_checker.sv]
// Port-level assertions for the search core, bound to the top level.
`default_nettype none

module rsas_checker
  import rsas_pkg::*;
(
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_valid_i,
  input wire logic                     in_ready_o,
  input wire logic        [OP_W-1:0]   operation_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic                     found_o,
  input wire logic        [POS_W-1:0]  position_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(position_o))
    else $error("result beat changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> position_o == '0)
    else $error("position not zero on a miss");

  // the input side is not ready straight after a search is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OP_SEARCH |=> !in_ready_o)
    else $error("input ready straight after a search");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i != OP_SEARCH |=> in_ready_o)
    else $error("table update blocked the input");

  // no result beat appears without a search in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && $past(in_ready_o) && !$past(out_valid_o) |-> !out_valid_o)
    else $error("result beat without a search");

endmodule

bind rotated_sorted_array_search_core rsas_checker u_rsas_checker (.*);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the rotated sorted array search core.
module tb;
  import rsas_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned     N_DIRECTED = 25;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    logic              chk;
    logic              hit;
    logic [POS_W-1:0]  pos;
  } dir_row_t;

  // Expected results are typed in only where they are obvious; other rows use the predictor.
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    '{OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 10'd0},
    '{OP_UNUSED, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h7FFF_FFFF, 1'b1, 1'b1, 10'd0},
    '{OP_SEARCH, 32'h8000_0000, 1'b1, 1'b0, 10'd0},
    '{OP_CLEAR,  32'h0000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h0000_0005, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h0000_0009, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'hFFFF_FFF9, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h0000_0001, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h0000_0003, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h0000_0003, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h0000_0005, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h0000_0004, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h8000_0000, 1'b0, 1'b0, 10'd0},
    '{OP_CLEAR,  32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, 10'd0},
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{OP_APPEND, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0},
    '{OP_SEARCH, 32'hFFFF_FFFF, 1'b0, 1'b0, 10'd0}
  };

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic        [OP_W-1:0]   operation_i = OP_CLEAR;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     found_o;
  logic        [POS_W-1:0]  position_o;

  // Typed expectation travelling with the beat on offer.
  logic             row_chk = 1'b0;
  logic             row_hit = 1'b0;
  logic [POS_W-1:0] row_pos = '0;

  // Predictor state.
  logic signed [DATA_W-1:0] table_words [CAPACITY_DEF];
  logic        [POS_W:0]    table_len  = '0;
  logic signed [DATA_W-1:0] table_min  = '0;
  logic        [POS_W-1:0]  rotation   = '0;

  result_t search_results [$];
  int      error_count  = 0;
  int      beats_sent   = 0;
  int      hold_request = 0;
  bit      idle_on      = 1'b1;

  rotated_sorted_array_search_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .position_o  (position_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Binary search over logical indices, mapped through the rotation offset.
  function automatic result_t rotated_search(input logic signed [DATA_W-1:0] key);
    result_t r;
    int lo, hi, mid, phys;
    r  = '0;
    lo = 0;
    hi = int'(table_len) - 1;
    while (lo <= hi && !r.found) begin
      mid  = (lo + hi) / 2;
      phys = int'(rotation) + mid;
      if (phys >= int'(table_len)) phys -= int'(table_len);
      if (table_words[phys] == key) begin
        r.found    = 1'b1;
        r.position = mid[POS_W-1:0];
      end else if (table_words[phys] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : accept_mon
    result_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      case (operation_i)
        OP_CLEAR: begin
          table_len = '0;
          table_min = '0;
          rotation  = '0;
        end
        OP_APPEND: begin
          if (table_len < CAPACITY_DEF) begin
            table_words[table_len] = value_i;
            if (table_len == 0 || value_i < table_min) begin
              table_min = value_i;
              rotation  = table_len[POS_W-1:0];
            end
            table_len = table_len + 1'b1;
          end
        end
        OP_SEARCH: begin
          if (row_chk) begin
            r.found    = row_hit;
            r.position = row_pos;
          end else begin
            r = rotated_search(value_i);
          end
          search_results.push_back(r);
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : result_mon
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (search_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                  found_o, position_o));
      end else begin
        want = search_results.pop_front();
        if (found_o !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b", found_o, want.found));
        if (position_o !== want.position)
          report_mismatch($sformatf("position %0d, expected %0d", position_o, want.position));
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin : receiver
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                           input logic chk = 1'b0, input logic hit = 1'b0,
                           input logic [POS_W-1:0] pos = '0);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    row_chk     <= chk;
    row_hit     <= hit;
    row_pos     <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    if (op != OP_UNUSED) beats_sent++;
  endtask

  // Load a rotated sorted table, then search it. Optional noise, a corrupted
  // element, appends past capacity and a long receiver hold.
  task automatic run_table(input int n, input bit corrupt, input int overflow,
                           input bit squeeze);
    int     vals [$];
    longint cur, step_lo, step_hi, slack, offs;
    int     rot, k, searches, key, bad;
    case ($urandom_range(0, 7))
      0:       step_hi = 0;
      1, 2:    step_hi = 2;
      default: step_hi = 64'd4294967295 / (n + 1);
    endcase
    step_lo = (step_hi > 2) ? 1 : 0;
    slack   = 64'd4294967295 - step_hi * n;
    cur     = -64'sd2147483648;
    if ($urandom_range(0, 7) != 0) begin
      offs = $urandom_range(0, slack);
      cur += offs;
    end
    for (k = 0; k < n; k++) begin
      vals.push_back(int'(cur));
      cur += $urandom_range(step_lo, step_hi);
    end
    bad = corrupt ? $urandom_range(0, n - 1) : -1;
    rot = $urandom_range(0, n - 1);
    send_beat(OP_CLEAR, $urandom);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) send_beat(OP_UNUSED, $urandom);
      if ($urandom_range(0, 29) == 0) send_beat(OP_SEARCH, vals[$urandom_range(0, n - 1)]);
      if (k == bad) vals[(rot + k) % n] = $urandom;
      send_beat(OP_APPEND, vals[(rot + k) % n]);
    end
    // drop these: the table is full
    repeat (overflow) send_beat(OP_APPEND, $urandom);
    searches = $urandom_range(1, 10);
    if (squeeze) begin
      searches     = 12;
      hold_request = 250;
    end
    repeat (searches) begin
      case ($urandom_range(0, 9))
        0, 1:    key = $urandom;
        2:       key = vals[$urandom_range(0, n - 1)] + 1;
        3:       key = vals[$urandom_range(0, n - 1)] - 1;
        default: key = vals[$urandom_range(0, n - 1)];
      endcase
      send_beat(OP_SEARCH, key);
    end
  endtask

  initial begin : stimulus
    int mark, guard;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED[i])
      send_beat(DIRECTED[i].op, DIRECTED[i].val, DIRECTED[i].chk, DIRECTED[i].hit,
                DIRECTED[i].pos);
    run_table(CAPACITY_DEF, 1'b0, 6, 1'b1);
    mark = beats_sent;
    while (beats_sent - mark < 750) begin
      idle_on = (beats_sent - mark < 650) && ($urandom_range(0, 3) != 0);
      run_table(($urandom_range(0, 5) == 0) ? $urandom_range(17, 100) : $urandom_range(1, 16),
                $urandom_range(0, 7) == 0, 0, 1'b0);
    end
    in_valid_i <= 1'b0;
    guard = 0;
    while (search_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (40) @(posedge clk_i);
    if (search_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", search_results.size()));
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
